>>> hdl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg - shared types and constants for the selectable string hash
// Algorithm codes, register indexes, hash constants and the state word
// passed between the mixer and the top level.
// ----------------------------------------------------------------------------
package ssh_pkg;

    // algorithm register codes
    localparam logic [3:0] ALG_AP   = 4'd0;
    localparam logic [3:0] ALG_BP   = 4'd1;
    localparam logic [3:0] ALG_JS   = 4'd2;
    localparam logic [3:0] ALG_RS   = 4'd3;
    localparam logic [3:0] ALG_ELF  = 4'd4;
    localparam logic [3:0] ALG_DEK  = 4'd5;
    localparam logic [3:0] ALG_FNV  = 4'd6;
    localparam logic [3:0] ALG_DJB2 = 4'd7;
    localparam logic [3:0] ALG_SDBM = 4'd8;
    localparam logic [3:0] ALG_BKDR = 4'd9;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALGORITHM = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BKDR_MULT = 1'b1;

    // sampling threshold on string length
    localparam logic [31:0] SAMPLE_LIMIT = 32'd64;

    // hash constants
    localparam logic [31:0] AP_INIT        = 32'hAAAA_AAAA;
    localparam logic [31:0] JS_INIT        = 32'd1315423911;
    localparam logic [31:0] RS_FACTOR_INIT = 32'd63689;
    localparam logic [31:0] RS_FACTOR_MULT = 32'd378551;
    localparam logic [31:0] ELF_TOP_MASK   = 32'hF000_0000;
    localparam logic [31:0] FNV_BASIS      = 32'h811C_9DC5;
    localparam logic [31:0] DJB2_INIT      = 32'd5381;
    localparam logic [31:0] BKDR_MULT_INIT = 32'd131;

    // per-string mixing state
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] rs_factor;
        logic        odd_sample;
    } mix_state_t;

endpackage

>>> hdl/ssh_mixer.sv
// ----------------------------------------------------------------------------
// ssh_mixer - one-byte hash update
// Combinational absorb of one sampled byte for the selected algorithm.
// One 32x32 multiplier is shared by RS, FNV and BKDR; RS also scales its factor by a constant.
// ----------------------------------------------------------------------------
module ssh_mixer (
    input  logic [3:0]          algorithm,
    input  logic [31:0]         bkdr_multiplier,
    input  logic [7:0]          data_byte,
    input  ssh_pkg::mix_state_t state_in,
    output ssh_pkg::mix_state_t state_out
);
    import ssh_pkg::*;

    logic [31:0] h;
    logic [31:0] c;
    logic [31:0] mul_a;
    logic [31:0] product;
    logic [31:0] elf_sum;
    logic [31:0] elf_top;

    assign h = state_in.hash;
    assign c = {24'd0, data_byte};

    // shared multiplier operand
    always_comb begin
        unique case (algorithm)
            ALG_RS:  mul_a = state_in.rs_factor;
            ALG_FNV: mul_a = FNV_BASIS;
            default: mul_a = bkdr_multiplier;
        endcase
    end

    assign product = mul_a * h;
    assign elf_sum = c + (h << 4);
    assign elf_top = elf_sum & ELF_TOP_MASK;

    always_comb begin
        state_out = state_in;
        unique case (algorithm)
            ALG_AP: begin
                if (state_in.odd_sample) begin
                    state_out.hash = h ^ ~(c ^ (h << 11) ^ (h >> 5));
                end else begin
                    state_out.hash = h ^ (c ^ (h << 7) ^ (h >> 3));
                end
                state_out.odd_sample = ~state_in.odd_sample;
            end
            ALG_BP:   state_out.hash = c ^ (h << 7);
            ALG_JS:   state_out.hash = h ^ (c + (h << 5) + (h >> 2));
            ALG_RS: begin
                state_out.hash      = c + product;
                state_out.rs_factor = state_in.rs_factor * RS_FACTOR_MULT;
            end
            // clearing the top nibble is a no-op when it is already zero
            ALG_ELF:  state_out.hash = (elf_sum ^ (elf_top >> 24)) & ~elf_top;
            ALG_DEK:  state_out.hash = c ^ (h << 5) ^ (h >> 27);
            ALG_FNV:  state_out.hash = c ^ product;
            ALG_DJB2: state_out.hash = c + (h << 5) + h;
            ALG_SDBM: state_out.hash = c + (h << 6) + (h << 16) - h;
            ALG_BKDR: state_out.hash = c + product;
            default:  state_out = state_in;
        endcase
    end

endmodule

>>> hdl/selectable_string_hash.sv
// ----------------------------------------------------------------------------
// selectable_string_hash - streaming 32-bit string hash, ten algorithms
// Byte-per-beat string hasher with length-driven sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one string byte per beat. The first beat of a
//   string has s_tuser high and carries the string length; the beat with
//   s_tlast high makes the block return the hash on the master stream.
//   An empty string is one beat with length 0; its hash is the initial value.
//   Strings longer than SAMPLE_LIMIT bytes are sampled: every step-th byte
//   is hashed, step = length / SAMPLE_LIMIT + 1.
//   Config channel writes the algorithm (index 0) and BKDR multiplier
//   (index 1); write only while the block is idle. cfg_ready is always high.
// Timing:
//   One beat per cycle sustained while no last beat waits for a held
//   result. A beat lands in the input register and is mixed from there
//   straight into the result register, which raises m_tvalid. The rate is
//   set by the combinational hash update loop (a shared 32x32 multiplier).
// Reset (aresetn low, synchronous): empties both registers, restores the
//   register defaults (AP, multiplier 131) and clears the string state.
// Stall: a held result blocks a further last beat and, behind it, s_tready;
//   other beats keep flowing through the input register while m_tready is low.
// ----------------------------------------------------------------------------
module selectable_string_hash (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ssh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    // slave stream: string bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] string_length
    input  logic        s_tuser,   // first_byte
    input  logic        s_tlast,   // last_byte
    // master stream: hashes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);
    import ssh_pkg::*;

    // ---- configuration registers -----------------------------------------
    logic [3:0]  algorithm_reg;
    logic [31:0] bkdr_mult_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            algorithm_reg <= ALG_AP;
            bkdr_mult_reg <= BKDR_MULT_INIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ALGORITHM: algorithm_reg <= cfg_data[3:0];
                REG_BKDR_MULT: bkdr_mult_reg <= cfg_data;
                default:       algorithm_reg <= algorithm_reg;
            endcase
        end
    end

    // ---- input register --------------------------------------------------
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_len_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic        proc_fire;
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;

    // a last beat needs a free result slot; other beats never wait
    assign proc_fire = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata[7:0];
            in_len_reg   <= s_tdata[39:8];
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // ---- string state ----------------------------------------------------
    mix_state_t  mix_reg;
    logic [31:0] step_reg;
    logic [31:0] skip_reg;
    logic [31:0] left_reg;

    mix_state_t  mix_start;
    mix_state_t  mix_absorbed;
    mix_state_t  mix_next;
    logic [31:0] step_start;
    logic [31:0] skip_start;
    logic [31:0] left_start;
    logic [31:0] step_next;
    logic [31:0] skip_next;
    logic [31:0] left_next;
    logic [32:0] step_wide;
    logic [31:0] init_hash;

    // initial hash value of a new string
    always_comb begin
        unique case (algorithm_reg)
            ALG_AP:   init_hash = AP_INIT;
            ALG_JS:   init_hash = JS_INIT;
            ALG_DEK:  init_hash = in_len_reg;
            ALG_DJB2: init_hash = DJB2_INIT;
            default:  init_hash = 32'd0;
        endcase
    end

    // sample step, saturated to 32 bits
    always_comb begin
        if (in_len_reg > SAMPLE_LIMIT) begin
            step_wide = {1'b0, in_len_reg / SAMPLE_LIMIT} + 33'd1;
        end else begin
            step_wide = 33'd1;
        end
    end

    // first beat restarts the string state before the byte is absorbed
    always_comb begin
        if (in_first_reg) begin
            mix_start.hash       = init_hash;
            mix_start.rs_factor  = RS_FACTOR_INIT;
            mix_start.odd_sample = 1'b0;
            step_start = step_wide[32] ? 32'hFFFF_FFFF : step_wide[31:0];
            skip_start = 32'd0;
            left_start = in_len_reg;
        end else begin
            mix_start  = mix_reg;
            step_start = step_reg;
            skip_start = skip_reg;
            left_start = left_reg;
        end
    end

    ssh_mixer u_mixer (
        .algorithm       (algorithm_reg),
        .bkdr_multiplier (bkdr_mult_reg),
        .data_byte       (in_byte_reg),
        .state_in        (mix_start),
        .state_out       (mix_absorbed)
    );

    // bytes past the length are ignored; skipped bytes only count down
    always_comb begin
        mix_next  = mix_start;
        step_next = step_start;
        skip_next = skip_start;
        left_next = left_start;
        if (left_start != 32'd0) begin
            left_next = left_start - 32'd1;
            if (skip_start == 32'd0) begin
                mix_next  = mix_absorbed;
                skip_next = step_start - 32'd1;
            end else begin
                skip_next = skip_start - 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_reg.hash       <= 32'd0;
            mix_reg.rs_factor  <= RS_FACTOR_INIT;
            mix_reg.odd_sample <= 1'b0;
            step_reg           <= 32'd1;
            skip_reg           <= 32'd0;
            left_reg           <= 32'd0;
        end else if (proc_fire) begin
            mix_reg  <= mix_next;
            step_reg <= step_next;
            skip_reg <= skip_next;
            left_reg <= left_next;
        end
    end

    // ---- result register -------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_last_reg) begin
            out_hash_reg <= mix_next.hash;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

endmodule
